// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for the frame check stage, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK_RST(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
`define ASSERT_CLK(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_CLK(label, clk_sig, prop, msg)
`endif

`endif

// ===== rtl/core/mrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU request frame checker package
// Transaction types, codes, constants and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam int COUNT_W = 9;

  localparam logic [15:0]        CRC_POLY          = 16'hA001;
  localparam logic [15:0]        CRC_INIT          = 16'hFFFF;
  localparam logic [COUNT_W-1:0] SHORT_FRAME_LEN   = 9'd8;
  localparam logic [COUNT_W-1:0] MULTI_FIXED_LEN   = 9'd9;
  localparam logic [COUNT_W-1:0] MAX_FRAME_LEN     = 9'd264;
  localparam logic [COUNT_W-1:0] POS_FUNC_CODE     = 9'd1;
  localparam logic [COUNT_W-1:0] POS_BYTE_COUNT    = 9'd6;
  localparam logic [7:0]         SHORT_CODE_MIN    = 8'h01;
  localparam logic [7:0]         SHORT_CODE_MAX    = 8'h06;
  localparam logic [7:0]         CODE_WRITE_COILS  = 8'h0F;
  localparam logic [7:0]         CODE_WRITE_REGS   = 8'h10;
  localparam logic [7:0]         COUNT_LIMIT_RESET = 8'd122;

  localparam int          PADDR_W            = 3;
  localparam logic        REG_MAX_DATA_BYTES = 1'b0;

  typedef enum logic [1:0] {
    VERDICT_OK,
    VERDICT_CRC_ERR,
    VERDICT_BAD_CODE,
    VERDICT_COUNT_HIGH
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [COUNT_W-1:0] frame_length;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mrtu_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register port holding the byte count limit.
// ----------------------------------------------------------------------------
module mrtu_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrtu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [7:0]                  max_data_bytes
);

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[mrtu_pkg::PADDR_W-1] == mrtu_pkg::REG_MAX_DATA_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_bytes <= mrtu_pkg::COUNT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_data_bytes <= pwdata[7:0];
    end
  end

  assign prdata = reg_hit ? {24'h000000, max_data_bytes} : 32'h00000000;

endmodule

// ===== rtl/core/mrtu_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte transaction until the checker consumes it.
// ----------------------------------------------------------------------------
module mrtu_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  mrtu_pkg::item_t item,
  input  logic            take,
  output logic            held_valid,
  output mrtu_pkg::item_t held_item
);

  assign item_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

endmodule

// ===== rtl/core/mrtu_frame_check.sv =====
// ----------------------------------------------------------------------------
// Frame check stage
// Tracks frame state, updates the CRC and registers the verdict transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrtu_frame_check (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        max_data_bytes,
  input  logic              held_valid,
  input  mrtu_pkg::item_t   held_item,
  output logic              take,
  output logic              result_valid,
  input  logic              result_ready,
  output mrtu_pkg::result_t result
);

  localparam int CW = mrtu_pkg::COUNT_W;

  logic [CW-1:0] bytes_seen;
  logic [15:0]   running_crc;
  logic [7:0]    held0;
  logic [7:0]    held1;
  logic [7:0]    function_code;
  logic [CW-1:0] expected_length;
  logic          verdict_given;

  logic          start;
  logic          active;
  logic [CW-1:0] pos;
  logic [15:0]   crc_base;
  logic [7:0]    h0_base;
  logic [7:0]    h1_base;
  logic [7:0]    fc_base;
  logic [CW-1:0] el_base;

  logic [CW-1:0] bytes_seen_next;
  logic [15:0]   running_crc_next;
  logic [7:0]    function_code_next;
  logic [CW-1:0] expected_length_next;
  logic          verdict_given_next;

  logic          short_code;
  logic          multi_code;
  logic [CW-1:0] length_limit;
  logic          at_eighth;
  logic          emit;
  mrtu_pkg::result_t result_next;

  assign take   = held_valid && (!result_valid || result_ready);
  assign start  = held_item.frame_start;
  assign active = start || !verdict_given;

  always_comb begin
    pos      = start ? '0 : bytes_seen;
    crc_base = start ? mrtu_pkg::CRC_INIT : running_crc;
    h0_base  = start ? 8'h00 : held0;
    h1_base  = start ? 8'h00 : held1;
    fc_base  = start ? 8'h00 : function_code;
    el_base  = start ? '0 : expected_length;

    running_crc_next = (|pos[CW-1:1]) ? mrtu_pkg::crc_feed(crc_base, h0_base) : crc_base;
    function_code_next = (pos == mrtu_pkg::POS_FUNC_CODE) ? held_item.data_byte : fc_base;

    short_code = (function_code_next >= mrtu_pkg::SHORT_CODE_MIN) &&
                 (function_code_next <= mrtu_pkg::SHORT_CODE_MAX);
    multi_code = (function_code_next == mrtu_pkg::CODE_WRITE_COILS) ||
                 (function_code_next == mrtu_pkg::CODE_WRITE_REGS);

    if ((pos == mrtu_pkg::POS_FUNC_CODE) && short_code) begin
      expected_length_next = mrtu_pkg::SHORT_FRAME_LEN;
    end else if ((pos == mrtu_pkg::POS_BYTE_COUNT) && multi_code) begin
      expected_length_next = {1'b0, held_item.data_byte} + mrtu_pkg::MULTI_FIXED_LEN;
    end else begin
      expected_length_next = el_base;
    end

    bytes_seen_next = (pos != {CW{1'b1}}) ? pos + 1'b1 : pos;
    length_limit    = {1'b0, max_data_bytes} + mrtu_pkg::MULTI_FIXED_LEN;
    at_eighth       = (bytes_seen_next == mrtu_pkg::SHORT_FRAME_LEN);

    emit                     = 1'b0;
    result_next.verdict      = mrtu_pkg::VERDICT_OK;
    result_next.frame_length = '0;
    if (at_eighth && !short_code && !multi_code) begin
      emit                = 1'b1;
      result_next.verdict = mrtu_pkg::VERDICT_BAD_CODE;
    end else if (at_eighth && multi_code && (expected_length_next > length_limit)) begin
      emit                = 1'b1;
      result_next.verdict = mrtu_pkg::VERDICT_COUNT_HIGH;
    end else if ((bytes_seen_next >= mrtu_pkg::SHORT_FRAME_LEN) &&
                 (bytes_seen_next == expected_length_next)) begin
      emit = 1'b1;
      if ((running_crc_next == {h1_base, held_item.data_byte}) ||
          (running_crc_next == {held_item.data_byte, h1_base})) begin
        result_next.frame_length = expected_length_next;
      end else begin
        result_next.verdict = mrtu_pkg::VERDICT_CRC_ERR;
      end
    end

    verdict_given_next = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      running_crc     <= mrtu_pkg::CRC_INIT;
      held0           <= 8'h00;
      held1           <= 8'h00;
      function_code   <= 8'h00;
      expected_length <= '0;
      verdict_given   <= 1'b1;
    end else if (take && active) begin
      bytes_seen      <= bytes_seen_next;
      running_crc     <= running_crc_next;
      held0           <= h1_base;
      held1           <= held_item.data_byte;
      function_code   <= function_code_next;
      expected_length <= expected_length_next;
      verdict_given   <= verdict_given_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= active && emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active && emit) begin
      result <= result_next;
    end
  end

  `ASSERT_CLK_RST(a_ok_has_length, clk, rst, result_valid && (result.verdict == mrtu_pkg::VERDICT_OK) |-> (result.frame_length >= mrtu_pkg::SHORT_FRAME_LEN) && (result.frame_length <= mrtu_pkg::MAX_FRAME_LEN), "valid frame with bad length")
  `ASSERT_CLK_RST(a_err_zero_length, clk, rst, result_valid && (result.verdict != mrtu_pkg::VERDICT_OK) |-> (result.frame_length == '0), "error verdict with nonzero length")
  `ASSERT_CLK_RST(a_verdict_closes, clk, rst, take && active && emit |=> verdict_given && result_valid, "verdict did not close frame")
  `ASSERT_CLK_RST(a_count_bound, clk, rst, !verdict_given |-> (bytes_seen < mrtu_pkg::MAX_FRAME_LEN), "frame ran past longest length")

endmodule

// ===== rtl/core/modbus_rtu_request_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU request frame checker
// Checks Modbus RTU request frames byte by byte and reports at most one verdict per frame.
//
//   channel   ports                               direction  payload
//   item      item_valid / item_ready / item      in         mrtu_pkg::item_t
//   result    result_valid / result_ready / result out       mrtu_pkg::result_t
//   config    psel penable pwrite paddr pwdata    in/out     max_data_bytes
//
// One byte transaction per cycle, sustained while results are accepted; the CRC update is one unrolled byte step.
// The byte that completes the frame passes through the input register; the verdict transaction is then registered.
// A result waiting on result_ready stalls the check stage; the input register
// can still hold one more byte.
// Reset clears the frame state; bytes without a start mark are then dropped.
// ----------------------------------------------------------------------------
module modbus_rtu_request_frame_checker_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  mrtu_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output mrtu_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrtu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic            held_valid;
  mrtu_pkg::item_t held_item;
  logic            take;
  logic [7:0]      max_data_bytes;

  mrtu_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_data_bytes (max_data_bytes)
  );

  mrtu_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mrtu_frame_check u_check (
    .clk            (clk),
    .rst            (rst),
    .max_data_bytes (max_data_bytes),
    .held_valid     (held_valid),
    .held_item      (held_item),
    .take           (take),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

endmodule

// ===== tb/sv/modbus_rtu_request_frame_checker_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU request frame checker testbench
// Streams request bytes into the checker and predicts each frame verdict
// (length, function code, byte count limit, CRC-16 in either byte order)
// with an independent model. Verdicts are checked in order. The byte count
// limit is reprogrammed over the APB port between traffic phases.
// ----------------------------------------------------------------------------
module modbus_rtu_request_frame_checker_unit_test;
  import mrtu_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [PADDR_W-1:0] MAX_BYTES_ADDR = PADDR_W'(4 * REG_MAX_DATA_BYTES);
  localparam logic [PADDR_W-1:0] SPARE_ADDR     = PADDR_W'(4 * (REG_MAX_DATA_BYTES + 1));

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  result_t            expected_verdicts[$];
  logic [7:0]         frame_buf[$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 hold_req = 1'b0;

  logic [7:0]         cfg_max_bytes;
  logic [COUNT_W-1:0] fr_count;
  logic [15:0]        fr_crc;
  logic [7:0]         fr_tail[2];
  logic [7:0]         fr_code;
  logic [COUNT_W-1:0] fr_length;
  logic               fr_closed;

  modbus_rtu_request_frame_checker_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic predict_verdict(input item_t it);
    logic [COUNT_W-1:0] pos;
    logic               short_c;
    logic               multi_c;
    logic [15:0]        hi_lo;
    logic [15:0]        lo_hi;
    if (it.frame_start) begin
      fr_count  = '0;
      fr_crc    = CRC_INIT;
      fr_tail   = '{default: '0};
      fr_code   = '0;
      fr_length = '0;
      fr_closed = 1'b0;
    end else if (fr_closed) begin
      return;
    end
    pos = fr_count;
    if (pos >= 2) fr_crc = crc16_next(fr_crc, fr_tail[0]);
    fr_tail[0] = fr_tail[1];
    fr_tail[1] = it.data_byte;
    if (pos == POS_FUNC_CODE) fr_code = it.data_byte;
    short_c = fr_code >= SHORT_CODE_MIN && fr_code <= SHORT_CODE_MAX;
    multi_c = fr_code == CODE_WRITE_COILS || fr_code == CODE_WRITE_REGS;
    if (pos == POS_FUNC_CODE && short_c) fr_length = SHORT_FRAME_LEN;
    if (pos == POS_BYTE_COUNT && multi_c) fr_length = {1'b0, it.data_byte} + MULTI_FIXED_LEN;
    if (fr_count != '1) fr_count++;
    if (fr_count == SHORT_FRAME_LEN && !short_c && !multi_c) begin
      fr_closed = 1'b1;
      expected_verdicts.push_back(result_t'{VERDICT_BAD_CODE, '0});
      return;
    end
    if (fr_count == SHORT_FRAME_LEN && multi_c &&
        fr_length > {1'b0, cfg_max_bytes} + MULTI_FIXED_LEN) begin
      fr_closed = 1'b1;
      expected_verdicts.push_back(result_t'{VERDICT_COUNT_HIGH, '0});
      return;
    end
    if (fr_count >= SHORT_FRAME_LEN && fr_count == fr_length) begin
      fr_closed = 1'b1;
      hi_lo = {fr_tail[0], fr_tail[1]};
      lo_hi = {fr_tail[1], fr_tail[0]};
      if (fr_crc == hi_lo || fr_crc == lo_hi) begin
        expected_verdicts.push_back(result_t'{VERDICT_OK, fr_length});
      end else begin
        expected_verdicts.push_back(result_t'{VERDICT_CRC_ERR, '0});
      end
    end
  endtask

  task automatic check_verdict(input result_t got);
    result_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected verdict %0d, frame_length %0d", got.verdict, got.frame_length);
      error_count++;
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.verdict !== want.verdict) begin
      $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
      error_count++;
    end
    if (got.frame_length !== want.frame_length) begin
      $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_verdict(result);
      if (item_valid && item_ready) predict_verdict(item);
    end
  end

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        result_ready <= 1'b1;
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= item_t'{data_byte: b, frame_start: s};
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic send_frame;
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == 0);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic build_frame(input logic [7:0] code, input logic [7:0] count,
                             input bit corrupt, input bit swap);
    logic [15:0] crc;
    frame_buf.delete();
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(code);
    repeat (4) frame_buf.push_back(8'($urandom));
    if (code == CODE_WRITE_COILS || code == CODE_WRITE_REGS) begin
      frame_buf.push_back(count);
      repeat (count) frame_buf.push_back(8'($urandom));
    end
    crc = CRC_INIT;
    foreach (frame_buf[i]) crc = crc16_next(crc, frame_buf[i]);
    if (corrupt) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    if (swap) begin
      frame_buf.push_back(crc[15:8]);
      frame_buf.push_back(crc[7:0]);
    end else begin
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_max_bytes(input logic [7:0] want);
    logic [31:0] rd;
    apb_access(1'b0, MAX_BYTES_ADDR, '0, rd);
    if (rd[7:0] !== want) begin
      $error("max_data_bytes: expected %0d, got %0d", want, rd[7:0]);
      error_count++;
    end
  endtask

  task automatic set_max_bytes(input logic [7:0] v);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, MAX_BYTES_ADDR, {24'($urandom), v}, rd);
    cfg_max_bytes = v;
    check_max_bytes(v);
  endtask

  task automatic test_register_access;
    logic [31:0] rd;
    check_max_bytes(COUNT_LIMIT_RESET);
    apb_access(1'b1, SPARE_ADDR, 32'($urandom), rd);
    check_max_bytes(COUNT_LIMIT_RESET);
  endtask

  task automatic test_special_frames;
    send_byte(8'hFF, 1'b0);
    build_frame(SHORT_CODE_MAX, '0, 1'b0, 1'b1);
    send_frame();
    build_frame('0, '0, 1'b0, 1'b0);
    send_frame();
    build_frame(CODE_WRITE_REGS, 8'd2, 1'b0, 1'b0);
    frame_buf = frame_buf[0:2];
    send_frame();
    build_frame(CODE_WRITE_REGS, '0, 1'b0, 1'b0);
    send_frame();
    build_frame(CODE_WRITE_COILS, COUNT_LIMIT_RESET + 8'd1, 1'b0, 1'b0);
    frame_buf = frame_buf[0:7];
    send_frame();
    build_frame(SHORT_CODE_MIN, '0, 1'b1, 1'b0);
    send_frame();
    send_byte(8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_count_limits;
    set_max_bytes(8'd0);
    build_frame(CODE_WRITE_REGS, 8'd0, 1'b0, 1'b0);
    send_frame();
    build_frame(CODE_WRITE_COILS, 8'd1, 1'b0, 1'b1);
    send_frame();
    set_max_bytes(8'd255);
    build_frame(CODE_WRITE_REGS, 8'd255, 1'b0, 1'b0);
    send_frame();
    wait_drained();
  endtask

  task automatic test_sender_pause;
    build_frame(CODE_WRITE_COILS, 8'd3, 1'b0, 1'b0);
    foreach (frame_buf[i]) begin
      if (i == 5) wait_drained();
      send_byte(frame_buf[i], i == 0);
    end
    wait_drained();
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    repeat (6) begin
      build_frame(SHORT_CODE_MIN + 8'($urandom_range(0, 5)), '0, 1'b0, 1'($urandom));
      send_frame();
    end
    @(negedge clk);
    item_valid <= 1'b0;
    while (hold_req) @(posedge clk);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int          done_bytes;
    int          kind;
    int          r;
    int          cut;
    logic [7:0]  code;
    logic [7:0]  count;
    done_bytes = 0;
    while (done_bytes < n_bytes) begin
      kind = $urandom_range(0, 99);
      r = $urandom_range(0, 7);
      code = r < 6 ? SHORT_CODE_MIN + 8'(r) : (r == 6 ? CODE_WRITE_COILS : CODE_WRITE_REGS);
      if ($urandom_range(0, 39) == 0) count = 8'($urandom_range(0, cfg_max_bytes));
      else count = 8'($urandom_range(0, cfg_max_bytes < 12 ? cfg_max_bytes : 12));
      if (kind >= 82 && kind < 87 && cfg_max_bytes == 8'hFF) kind = 0;
      if (kind < 65) begin
        build_frame(code, count, 1'b0, 1'($urandom));
      end else if (kind < 75) begin
        build_frame(code, count, 1'b1, 1'($urandom));
      end else if (kind < 82) begin
        do code = 8'($urandom);
        while ((code >= SHORT_CODE_MIN && code <= SHORT_CODE_MAX) ||
               code == CODE_WRITE_COILS || code == CODE_WRITE_REGS);
        build_frame(code, '0, 1'b0, 1'($urandom));
      end else if (kind < 87) begin
        count = 8'($urandom_range(cfg_max_bytes + 1, 255));
        build_frame($urandom_range(0, 1) ? CODE_WRITE_COILS : CODE_WRITE_REGS, count,
                    1'b0, 1'b0);
        frame_buf = frame_buf[0:7];
      end else if (kind < 92) begin
        build_frame(code, count, 1'b0, 1'b0);
        cut = $urandom_range(1, frame_buf.size() - 1);
        frame_buf = frame_buf[0:cut-1];
      end else if (kind < 96) begin
        build_frame(code, count, 1'b0, 1'($urandom));
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
      end
      send_frame();
      done_bytes += frame_buf.size();
      if (kind >= 92 && kind < 96) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_max_bytes = COUNT_LIMIT_RESET;
    fr_count      = '0;
    fr_crc        = CRC_INIT;
    fr_tail       = '{default: '0};
    fr_code       = '0;
    fr_length     = '0;
    fr_closed     = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    send_idle_pct = 25;
    recv_idle_pct = 25;
    test_special_frames();
    test_count_limits();
    test_sender_pause();
    test_backpressure();

    set_max_bytes(8'd0);
    test_random_traffic(300);
    send_idle_pct = 30;
    recv_idle_pct = 10;
    set_max_bytes(8'd255);
    test_random_traffic(300);
    send_idle_pct = 10;
    recv_idle_pct = 35;
    set_max_bytes(8'($urandom_range(1, 254)));
    test_random_traffic(300);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    set_max_bytes(COUNT_LIMIT_RESET);
    test_random_traffic(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_max_bytes(8'($urandom_range(1, 254)));
    test_random_traffic(400);
    wait_drained();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
